FILE: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers for the design folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked on every clock edge outside of reset.
`define LCW_ASSERT(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Checked on every clock edge, reset included.
`define LCW_ASSERT_ALWAYS(lbl, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: design/lcw_pkg.sv
// ----------------------------------------------------------------------------
// lcw_pkg
// Constants, types and helper functions of the color wheel frame generator.
// ----------------------------------------------------------------------------
package lcw_pkg;

    // LEDs on the strip; at most EMIT_COUNT colors go out per frame
    localparam int LED_COUNT  = 8;
    localparam int LED_W      = 3;
    localparam int EMIT_COUNT = (LED_COUNT < (1 << LED_W)) ? LED_COUNT : (1 << LED_W);

    localparam int STEP_W = 16;
    localparam int CHAN_W = 8;
    localparam int CFG_W  = 24;
    localparam int IDX_W  = 3;

    // register indexes
    localparam logic [IDX_W-1:0] REG_EFFECT_MODE  = 3'd0;
    localparam logic [IDX_W-1:0] REG_PHASE_SPREAD = 3'd1;
    localparam logic [IDX_W-1:0] REG_CYCLE_STEPS  = 3'd2;
    localparam logic [IDX_W-1:0] REG_BRIGHTNESS   = 3'd3;
    localparam logic [IDX_W-1:0] REG_STATIC_COLOR = 3'd4;

    typedef logic [CHAN_W-1:0] chan_t;

    typedef struct packed {
        chan_t r;
        chan_t g;
        chan_t b;
    } rgb_t;

    // reset values
    localparam logic          RST_EFFECT_MODE  = 1'b0;
    localparam logic          RST_PHASE_SPREAD = 1'b1;
    localparam logic [15:0]   RST_CYCLE_STEPS  = 16'd120;
    localparam chan_t         RST_BRIGHTNESS   = 8'd20;
    localparam rgb_t          RST_STATIC_COLOR = 24'hFFFFFF;

    localparam chan_t CHAN_FULL = 8'd255;

    // red - yellow - green - cyan - blue - magenta - red
    function automatic rgb_t wheel_at(input logic [2:0] idx);
        rgb_t c;
        unique case (idx)
            3'd0:    c = '{r: CHAN_FULL, g: 8'd0,      b: 8'd0};
            3'd1:    c = '{r: CHAN_FULL, g: CHAN_FULL, b: 8'd0};
            3'd2:    c = '{r: 8'd0,      g: CHAN_FULL, b: 8'd0};
            3'd3:    c = '{r: 8'd0,      g: CHAN_FULL, b: CHAN_FULL};
            3'd4:    c = '{r: 8'd0,      g: 8'd0,      b: CHAN_FULL};
            3'd5:    c = '{r: CHAN_FULL, g: 8'd0,      b: CHAN_FULL};
            default: c = '{r: CHAN_FULL, g: 8'd0,      b: 8'd0};
        endcase
        return c;
    endfunction

    // per-LED phase offset, led * 65536 / LED_COUNT
    function automatic logic [STEP_W-1:0] spread_of(input logic [LED_W-1:0] led);
        logic [31:0] num;
        num = 32'(led) << STEP_W;
        return STEP_W'(num / LED_COUNT);
    endfunction

    // wheel entries are 0 or full scale, so the ramp t covers every segment
    function automatic chan_t chan_blend(input chan_t a, input chan_t b, input chan_t t);
        chan_t v;
        if (b == a)
            v = a;
        else if (b > a)
            v = a + t;
        else
            v = a - t;
        return v;
    endfunction

    // floor(x / 255) for x up to 255 * 255
    function automatic chan_t div255(input logic [15:0] x);
        logic [16:0] y;
        y = {1'b0, x} + {9'b0, x[15:8]} + 17'd1;
        return y[15:8];
    endfunction

endpackage

FILE: design/led_color_wheel_frame_generator_core.sv
// ----------------------------------------------------------------------------
// led_color_wheel_frame_generator_core
// Frame tick in, one brightness-scaled color per LED out, hue wheel, static or blank.
// ----------------------------------------------------------------------------
//
//  Channel    Direction  Payload                                 Transfer
//  s_axis     in         tdata[0] blank                          tvalid & tready
//  m_axis     out        tdata led_index/red/green/blue, tlast   tvalid & tready
//  cfg        in         cfg_index selects register, cfg_data    cfg_we
//
//  A frame first runs the bit-serial phase divider (step << 16 over
//  cycle_steps), then works on each LED in turn: phase, blend, shift-add
//  brightness multiply, hand-off.
//  The next LED is worked on while the previous color waits in the output
//  register; the work halts at hand-off while that register stays full.
//  Reset clears step_reg and loads the register defaults; no clearing pass.
//  A new tick is taken only once the previous frame's last color is handed off.
//
`include "assert_macros.svh"

module led_color_wheel_frame_generator_core
    import lcw_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,

    input  logic             s_axis_tvalid,
    output logic             s_axis_tready,
    input  logic [7:0]       s_axis_tdata,   // [0] blank, [7:1] zero

    output logic             m_axis_tvalid,
    input  logic             m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [2:0] led_index, [10:3] red,
                                             // [18:11] green, [26:19] blue, [31:27] zero
    output logic             m_axis_tlast,

    input  logic             cfg_we,
    input  logic [IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0] cfg_data
);

    // sequencer codes
    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_DIV   = 3'd1;
    localparam logic [2:0] ST_PHASE = 3'd2;
    localparam logic [2:0] ST_BLEND = 3'd3;
    localparam logic [2:0] ST_MUL   = 3'd4;
    localparam logic [2:0] ST_HOLD  = 3'd5;

    localparam logic [4:0] DIV_LAST  = 5'(2 * STEP_W - 1);  // dividend is step << 16
    localparam logic [4:0] DIV_MID   = 5'(STEP_W - 1);      // step bits all shifted in
    localparam logic [4:0] MUL_LAST  = 5'(CHAN_W - 1);
    localparam logic [LED_W-1:0] LED_LAST = LED_W'(EMIT_COUNT - 1);

    // configuration registers
    logic              mode_reg;
    logic              spread_reg;
    logic [STEP_W-1:0] steps_reg;
    chan_t             bright_reg;
    rgb_t              color_reg;

    // control
    logic [2:0]        state_reg;
    logic [4:0]        cnt_reg;
    logic [LED_W-1:0]  led_reg;
    logic [STEP_W-1:0] step_reg;
    logic              out_valid_reg;

    // datapath
    logic              blank_reg;
    logic [STEP_W-1:0] divisor_reg;
    logic [STEP_W-1:0] dvd_reg;
    logic [STEP_W-1:0] rem_reg;
    logic [STEP_W-1:0] quo_reg;
    logic [STEP_W-1:0] mod_reg;
    logic [2:0]        seg_reg;
    logic [15:0]       frac_reg;
    chan_t             lvl_reg;
    chan_t             mcand_reg [3];
    logic [15:0]       acc_reg   [3];
    logic [LED_W-1:0]  out_led_reg;
    rgb_t              out_rgb_reg;
    logic              out_last_reg;

    logic              in_xfer;
    logic              out_free;
    logic              led_is_last;
    logic              frame_adv;

    logic [STEP_W:0]   trial;
    logic              ge;
    logic [STEP_W-1:0] rem_new;
    logic [STEP_W-1:0] step_inc;

    logic [15:0]       phase;
    logic [18:0]       p6;
    logic [23:0]       ramp;
    rgb_t              wa;
    rgb_t              wb;
    rgb_t              pick;

    assign in_xfer     = s_axis_tvalid && s_axis_tready;
    assign out_free    = !out_valid_reg || m_axis_tready;
    assign led_is_last = (led_reg == LED_LAST);
    assign frame_adv   = (state_reg == ST_HOLD) && out_free && led_is_last;

    assign s_axis_tready = (state_reg == ST_IDLE);
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {5'd0, out_rgb_reg.b, out_rgb_reg.g, out_rgb_reg.r, out_led_reg};

    // restoring divider, one dividend bit per cycle
    assign trial   = {rem_reg, dvd_reg[STEP_W-1]};
    assign ge      = (trial >= {1'b0, divisor_reg});
    assign rem_new = ge ? STEP_W'(trial - {1'b0, divisor_reg}) : trial[STEP_W-1:0];

    // remainder of step over the cycle length is below the divisor, so no carry
    assign step_inc = mod_reg + 16'd1;

    // wheel position of the current LED: segment in p6[18:16], fraction below
    assign phase = quo_reg + (spread_reg ? spread_of(led_reg) : 16'd0);
    assign p6    = {1'b0, phase, 2'b0} + {2'b0, phase, 1'b0};

    // 255 * frac >> 16 is the ramp shared by rising and falling channels
    assign ramp = {frac_reg, 8'd0} - {8'd0, frac_reg};
    assign wa   = wheel_at(seg_reg);
    assign wb   = wheel_at(seg_reg + 3'd1);

    always_comb
    begin
        if (blank_reg)
            pick = '0;
        else if (!mode_reg)
            pick = color_reg;
        else
        begin
            pick.r = chan_blend(wa.r, wb.r, ramp[23:16]);
            pick.g = chan_blend(wa.g, wb.g, ramp[23:16]);
            pick.b = chan_blend(wa.b, wb.b, ramp[23:16]);
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg   <= RST_EFFECT_MODE;
            spread_reg <= RST_PHASE_SPREAD;
            steps_reg  <= RST_CYCLE_STEPS;
            bright_reg <= RST_BRIGHTNESS;
            color_reg  <= RST_STATIC_COLOR;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_EFFECT_MODE:  mode_reg   <= cfg_data[0];
                REG_PHASE_SPREAD: spread_reg <= cfg_data[0];
                REG_CYCLE_STEPS:  steps_reg  <= cfg_data[STEP_W-1:0];
                REG_BRIGHTNESS:   bright_reg <= cfg_data[CHAN_W-1:0];
                REG_STATIC_COLOR: color_reg  <= cfg_data;
                default:          ;
            endcase
        end
    end

    // sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            led_reg       <= '0;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if ((state_reg == ST_HOLD) && out_free)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (in_xfer)
                    begin
                        state_reg <= ST_DIV;
                        cnt_reg   <= '0;
                        led_reg   <= '0;
                    end
                end
                ST_DIV:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == DIV_LAST)
                        state_reg <= ST_PHASE;
                end
                ST_PHASE:
                    state_reg <= ST_BLEND;
                ST_BLEND:
                begin
                    state_reg <= ST_MUL;
                    cnt_reg   <= '0;
                end
                ST_MUL:
                begin
                    cnt_reg <= cnt_reg + 5'd1;
                    if (cnt_reg == MUL_LAST)
                        state_reg <= ST_HOLD;
                end
                ST_HOLD:
                begin
                    if (out_free)
                    begin
                        if (led_is_last)
                        begin
                            state_reg <= ST_IDLE;
                            // wheel advances only on lit cycling frames
                            if (!blank_reg && mode_reg)
                                step_reg <= (step_inc == divisor_reg) ? '0 : step_inc;
                        end
                        else
                        begin
                            led_reg   <= led_reg + LED_W'(1);
                            state_reg <= ST_PHASE;
                        end
                    end
                end
                default:
                    state_reg <= ST_IDLE;
            endcase
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_xfer)
                begin
                    blank_reg   <= s_axis_tdata[0];
                    // zero cycle length behaves as one
                    divisor_reg <= (steps_reg == '0) ? 16'd1 : steps_reg;
                    dvd_reg     <= step_reg;
                    rem_reg     <= '0;
                    quo_reg     <= '0;
                end
            end
            ST_DIV:
            begin
                rem_reg <= rem_new;
                quo_reg <= {quo_reg[STEP_W-2:0], ge};   // upper quotient bits drop off
                dvd_reg <= {dvd_reg[STEP_W-2:0], 1'b0};
                if (cnt_reg == DIV_MID)
                    mod_reg <= rem_new;                 // step mod cycle length
            end
            ST_PHASE:
            begin
                seg_reg  <= p6[18:16];
                frac_reg <= p6[15:0];
            end
            ST_BLEND:
            begin
                mcand_reg[0] <= pick.r;
                mcand_reg[1] <= pick.g;
                mcand_reg[2] <= pick.b;
                for (int c = 0; c < 3; c++)
                    acc_reg[c] <= '0;
                lvl_reg <= bright_reg;
            end
            ST_MUL:
            begin
                // level bits MSB first
                for (int c = 0; c < 3; c++)
                    acc_reg[c] <= {acc_reg[c][14:0], 1'b0}
                                + (lvl_reg[CHAN_W-1] ? {8'd0, mcand_reg[c]} : 16'd0);
                lvl_reg <= {lvl_reg[CHAN_W-2:0], 1'b0};
            end
            ST_HOLD:
            begin
                if (out_free)
                begin
                    out_led_reg   <= led_reg;
                    out_rgb_reg.r <= div255(acc_reg[0]);
                    out_rgb_reg.g <= div255(acc_reg[1]);
                    out_rgb_reg.b <= div255(acc_reg[2]);
                    out_last_reg  <= led_is_last;
                end
            end
            default: ;
        endcase
    end

    `LCW_ASSERT(a_rem_below_div, (state_reg == ST_DIV) |-> (rem_reg < divisor_reg), "divider remainder out of range")
    `LCW_ASSERT(a_mod_below_div, (state_reg == ST_PHASE) |-> (mod_reg < divisor_reg), "step remainder out of range")
    `LCW_ASSERT(a_step_wraps, frame_adv && !blank_reg && mode_reg |=> (step_reg < divisor_reg), "step not reduced")
    `LCW_ASSERT_ALWAYS(a_last_on_final, (out_valid_reg && out_last_reg) |-> (out_led_reg == LED_LAST), "tlast off final LED")

endmodule
